[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain concurrent assertion, clocked on the rising edge, off while in reset
`define OWM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// overlapping implication on one edge
`define OWM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	`OWM_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// implication checked on the following edge
`define OWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	`OWM_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

[hw/rtl/owm_pkg.sv]
package owm_pkg;

	localparam int NREG       = 8;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PRESENCE_TAIL = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_SLOT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LONG_SLOT     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_READ_HOLD     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

	// register values after reset, index 0 in the low slot
	localparam logic [NREG-1:0][CFG_DATA_W-1:0] CFG_RESET = {
		12'd60, 12'd10, 12'd5, 12'd64, 12'd6, 12'd300, 12'd70, 12'd550
	};

	localparam logic [7:0] READ_MSB = 8'h80;

	typedef enum logic [2:0] {
		K_TICK  = 3'd0,
		K_RESET = 3'd1,
		K_WBYTE = 3'd2,
		K_RBYTE = 3'd3,
		K_WBIT  = 3'd4,
		K_RBIT  = 3'd5
	} cmd_kind_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_in;
		logic       line_level;
	} owm_item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       no_presence;
		logic [7:0] read_data;
		logic       rejected;
	} owm_res_t;

endpackage

[hw/rtl/owm_if.sv]
interface owm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] data_in;
	logic       line_level;

	modport source (output valid, kind, data_in, line_level, input ready);
	modport sink   (input valid, kind, data_in, line_level, output ready);
endinterface

interface owm_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       no_presence;
	logic [7:0] read_data;
	logic       rejected;

	modport source (output valid, drive_low, busy_res, done_res, no_presence, read_data,
		rejected, input ready);
	modport sink   (input valid, drive_low, busy_res, done_res, no_presence, read_data,
		rejected, output ready);
endinterface

interface owm_cfg_if import owm_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [REG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/owm_cfg_regs.sv]
module owm_cfg_regs import owm_pkg::*; #(
	parameter int CFG_W = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [REG_IDX_W-1:0]            wr_index,
	input  logic [CFG_DATA_W-1:0]           wr_data,
	output logic [NREG-1:0][CFG_W-1:0]      regs
);

	logic [NREG-1:0][CFG_W-1:0] regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) begin
				regs_q[i] <= CFG_RESET[i][CFG_W-1:0];
			end
		end else if (wr_en) begin
			regs_q[wr_index] <= wr_data[CFG_W-1:0];
		end
	end

	assign regs = regs_q;

endmodule

[hw/rtl/owm_seq.sv]
module owm_seq import owm_pkg::*; #(
	parameter int CFG_W          = 12,
	parameter int RECOVERY_TICKS = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step_en,
	input  owm_item_t                  item,
	input  logic [NREG-1:0][CFG_W-1:0] regs,
	output owm_res_t                   res_next
);

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_RST_LOW  = 4'd1,
		PH_RST_WAIT = 4'd2,
		PH_RST_TAIL = 4'd3,
		PH_RECOV    = 4'd4,
		PH_WR_LOW   = 4'd5,
		PH_WR_TAIL  = 4'd6,
		PH_RD_HOLD  = 4'd7,
		PH_RD_WAIT  = 4'd8,
		PH_RD_TAIL  = 4'd9
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [2:0]       op_q, op_d;
	logic [CFG_W-1:0] cnt_q, cnt_d;
	logic [3:0]       bit_q, bit_d;
	logic [7:0]       shift_q, shift_d;
	logic             pres_q, pres_d;

	logic [CFG_W-1:0] len;
	logic [CFG_W-1:0] cnt_inc;
	logic [3:0]       bit_inc;
	logic             slot_end;
	logic             fin;
	logic             rej;
	logic             byte_op;
	logic             write_op;
	logic [7:0]       fin_data;

	function automatic logic [CFG_W-1:0] at_least_one(input logic [CFG_W-1:0] v);
		return (v == '0) ? CFG_W'(1) : v;
	endfunction

	assign byte_op  = (op_q == K_WBYTE) || (op_q == K_RBYTE);
	assign write_op = (op_q == K_WBYTE) || (op_q == K_WBIT);
	assign cnt_inc  = cnt_q + CFG_W'(1);
	assign bit_inc  = bit_q + 4'd1;

	// length of the running phase, zero lengths count as one tick
	always_comb begin
		unique case (phase_q)
			PH_RST_LOW:  len = at_least_one(regs[REG_RESET_LOW]);
			PH_RST_WAIT: len = at_least_one(regs[REG_PRESENCE_WAIT]);
			PH_RST_TAIL: len = at_least_one(regs[REG_PRESENCE_TAIL]);
			PH_RECOV:    len = CFG_W'(RECOVERY_TICKS);
			PH_WR_LOW:   len = at_least_one(shift_q[0] ? regs[REG_SHORT_SLOT]
			                                           : regs[REG_LONG_SLOT]);
			PH_WR_TAIL:  len = at_least_one(shift_q[0] ? regs[REG_LONG_SLOT]
			                                           : regs[REG_SHORT_SLOT]);
			PH_RD_HOLD:  len = at_least_one(regs[REG_READ_HOLD]);
			PH_RD_WAIT:  len = at_least_one(regs[REG_READ_SAMPLE]);
			PH_RD_TAIL:  len = at_least_one(regs[REG_READ_TAIL]);
			default:     len = CFG_W'(1);
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		cnt_d    = cnt_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		pres_d   = pres_q;
		slot_end = 1'b0;
		fin      = 1'b0;
		rej      = 1'b0;

		unique case (item.kind)
			K_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (cnt_inc >= len) begin
						cnt_d = '0;
						unique case (phase_q)
							PH_RST_LOW: begin
								phase_d = PH_RST_WAIT;
							end
							PH_RST_WAIT: begin
								pres_d = item.line_level;
								if (item.line_level || (regs[REG_PRESENCE_TAIL] == '0)) begin
									fin     = 1'b1;
									phase_d = PH_IDLE;
								end else begin
									phase_d = PH_RST_TAIL;
								end
							end
							PH_RST_TAIL: begin
								fin     = 1'b1;
								phase_d = PH_IDLE;
							end
							PH_RECOV: begin
								phase_d = write_op ? PH_WR_LOW : PH_RD_HOLD;
							end
							PH_WR_LOW: begin
								phase_d = PH_WR_TAIL;
							end
							PH_WR_TAIL: begin
								shift_d  = {1'b0, shift_q[7:1]};
								slot_end = 1'b1;
							end
							PH_RD_HOLD: begin
								phase_d = PH_RD_WAIT;
							end
							PH_RD_WAIT: begin
								if (op_q == K_RBIT) begin
									shift_d = {7'd0, item.line_level};
								end else begin
									shift_d = {1'b0, shift_q[7:1]} |
										(item.line_level ? READ_MSB : 8'd0);
								end
								if (regs[REG_READ_TAIL] == '0) begin
									slot_end = 1'b1;
								end else begin
									phase_d = PH_RD_TAIL;
								end
							end
							PH_RD_TAIL: begin
								slot_end = 1'b1;
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
						// next bit of a byte, or the command is over
						if (slot_end) begin
							bit_d = bit_inc;
							if (byte_op && (bit_inc < 4'd8)) begin
								phase_d = PH_RECOV;
							end else begin
								fin     = 1'b1;
								phase_d = PH_IDLE;
							end
						end
					end else begin
						cnt_d = cnt_inc;
					end
				end
			end
			K_RESET, K_WBYTE, K_RBYTE, K_WBIT, K_RBIT: begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					op_d  = item.kind;
					bit_d = 4'd0;
					cnt_d = '0;
					unique case (item.kind)
						K_RESET: begin
							shift_d = 8'd0;
							phase_d = PH_RST_LOW;
						end
						K_WBYTE: begin
							shift_d = item.data_in;
							phase_d = PH_RECOV;
						end
						K_WBIT: begin
							shift_d = {7'd0, item.data_in[0]};
							phase_d = PH_RECOV;
						end
						default: begin
							shift_d = 8'd0;
							phase_d = PH_RECOV;
						end
					endcase
				end
			end
			default: begin
				// unused kind codes leave everything as it is
			end
		endcase
	end

	always_comb begin
		if (fin && (op_q == K_RBYTE)) begin
			fin_data = shift_d;
		end else if (fin && (op_q == K_RBIT)) begin
			fin_data = {7'd0, shift_d[0]};
		end else begin
			fin_data = 8'd0;
		end
	end

	assign res_next.drive_low   = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
	                              (phase_d == PH_RD_HOLD);
	assign res_next.busy_res    = (phase_d != PH_IDLE);
	assign res_next.done_res    = fin;
	assign res_next.no_presence = pres_d;
	assign res_next.read_data   = fin_data;
	assign res_next.rejected    = rej;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q    <= 3'd0;
			cnt_q   <= '0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			pres_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			op_q    <= op_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
		end
	end

endmodule

[hw/rtl/onewire_bus_master_core.sv]
// One-wire bus master core. Drives a single open-drain line through the
// drive_low result bit and learns the line level from tick transfers on the
// command channel. A command transfer (bus reset, write byte, read byte,
// write bit, read bit) only starts an operation; every tick transfer is one
// unit of bus time, and each phase of the waveform lasts the number of ticks
// held in its configuration register. Bytes go least significant bit first,
// each bit slot opening with RECOVERY_TICKS released ticks. A command that
// arrives while one is in progress is dropped and flagged rejected. Every
// command transfer gives exactly one result transfer. Throughput is one
// transfer per clock while the output side is not stalled: a transfer is
// registered on entry, then the sequencer advances its state and the
// result lands in the output register on the same edge, once the output
// slot is free. The user must see that configuration registers are written
// only while no command work is pending; the block itself does not enforce
// it, and there is no clearing pass after reset.
module onewire_bus_master_core import owm_pkg::*; #(
	parameter int RECOVERY_TICKS = 2,
	parameter int TIMER_WIDTH    = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	owm_cmd_if.sink       cmd,
	owm_res_if.source     res,
	owm_cfg_if.sink       cfg
);

	// registers keep at most the 12 bits of the write data
	localparam int CFG_W = (TIMER_WIDTH < CFG_DATA_W) ? TIMER_WIDTH : CFG_DATA_W;

	logic                       valid_s1;
	owm_item_t                  item_s1;
	logic                       res_valid_q;
	owm_res_t                   res_q;
	owm_res_t                   res_next;
	logic                       out_free;
	logic                       advance;
	logic [NREG-1:0][CFG_W-1:0] regs;

	// output slot can take a result when empty or being drained
	assign out_free  = !res_valid_q || res.ready;
	// the registered transfer moves into the sequencer and the output slot
	assign advance   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	// writes are always taken
	assign cfg.ready = 1'b1;

	owm_cfg_regs #(
		.CFG_W (CFG_W)
	) u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.regs     (regs)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.kind       <= cmd.kind;
			item_s1.data_in    <= cmd.data_in;
			item_s1.line_level <= cmd.line_level;
		end
	end

	// bus state machine, steps once per transfer
	owm_seq #(
		.CFG_W          (CFG_W),
		.RECOVERY_TICKS (RECOVERY_TICKS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.item     (item_s1),
		.regs     (regs),
		.res_next (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.drive_low   = res_q.drive_low;
	assign res.busy_res    = res_q.busy_res;
	assign res.done_res    = res_q.done_res;
	assign res.no_presence = res_q.no_presence;
	assign res.read_data   = res_q.read_data;
	assign res.rejected    = res_q.rejected;

endmodule

[hw/rtl/owm_checker.sv]
`include "assert_macros.svh"

module owm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data,
	input logic       rejected
);

	// a stalled result stays put
	`OWM_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready,
		res_valid && $stable(read_data) && $stable(done_res) && $stable(busy_res),
		"stalled result changed")
	// a finishing command leaves the block idle
	`OWM_ASSERT_IMPLIES(a_done_idle, clk, arst_n, res_valid && done_res, !busy_res,
		"busy on a finishing result")
	// read data shows only on the finishing transfer
	`OWM_ASSERT_IMPLIES(a_data_on_done, clk, arst_n, res_valid && (read_data != 8'd0),
		done_res, "read data outside a finishing result")
	// a command is only dropped while another is running
	`OWM_ASSERT_IMPLIES(a_reject_busy, clk, arst_n, res_valid && rejected,
		busy_res && !done_res, "command dropped while idle")
	// the line is pulled only during a command
	`OWM_ASSERT_IMPLIES(a_drive_busy, clk, arst_n, res_valid && drive_low, busy_res,
		"line pulled while idle")

endmodule

bind onewire_bus_master_core owm_checker u_owm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.drive_low   (res.drive_low),
	.busy_res    (res.busy_res),
	.done_res    (res.done_res),
	.read_data   (res.read_data),
	.rejected    (res.rejected)
);
